// ----- sv/mbr_pkg.sv -----
// ----------------------------------------------------------------------------
// mbr_pkg: shared types and constants of the Modbus RTU frame receiver
// Item layouts for both channels, field codes and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbr_pkg;

    // Input item codes.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result item codes.
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR    = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW   = 2'd3;

    // Register indexes.
    localparam logic REG_SILENCE_TICKS = 1'b0;

    localparam logic [15:0] SILENCE_TICKS_RESET = 16'd80;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'hA001;
    localparam logic [15:0] SILENCE_MAX         = 16'hFFFF;
    localparam int unsigned MIN_GOOD_BYTES      = 4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [1:0]  status;
        logic [31:0] good_frames;
        logic [31:0] crc_errors;
        logic [31:0] incomplete_frames;
        logic [31:0] overflows;
    } t_out_item;

    // Folds one byte into the Modbus CRC, LSB first, eight shift steps.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/mbr_cfg.sv -----
// ----------------------------------------------------------------------------
// mbr_cfg: configuration register file
// APB-style slave holding the T3.5 silence length in timer ticks.
// ----------------------------------------------------------------------------
module mbr_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_silence_ticks
);
    import mbr_pkg::*;

    logic [15:0] r_silence_ticks;
    logic        wr_en;

    // The register index is the word address; byte offset bits are ignored.
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SILENCE_TICKS);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_ticks <= SILENCE_TICKS_RESET;
        end else if (wr_en) begin
            r_silence_ticks <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SILENCE_TICKS) begin
            prdata = {16'h0000, r_silence_ticks};
        end
    end

    assign o_silence_ticks = r_silence_ticks;

endmodule

// ----- sv/mbr_core.sv -----
// ----------------------------------------------------------------------------
// mbr_core: frame state, CRC check and result register
// Updates frame state, one item per cycle unless stalled, and holds the result.
// ----------------------------------------------------------------------------
module mbr_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_silence_ticks,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mbr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mbr_pkg::t_out_item o_out_item
);
    import mbr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_OVER = 2'd2;

    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_held0, n_held0;
    logic [7:0]    r_held1, n_held1;
    logic [15:0]   r_sil, n_sil;
    logic [31:0]   r_ok, n_ok;
    logic [31:0]   r_crc_err, n_crc_err;
    logic [31:0]   r_short, n_short;
    logic [31:0]   r_over, n_over;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          accept;
    logic          res_valid;
    t_out_item     res;
    logic          store;
    logic [8:0]    count_ext;
    logic [15:0]   sil_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign count_ext  = 9'(r_count);
    assign sil_inc    = (r_sil < SILENCE_MAX) ? r_sil + 16'd1 : r_sil;

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_crc     = r_crc;
        n_held0   = r_held0;
        n_held1   = r_held1;
        n_sil     = r_sil;
        n_ok      = r_ok;
        n_crc_err = r_crc_err;
        n_short   = r_short;
        n_over    = r_over;
        res_valid = 1'b0;
        res       = '0;
        store     = 1'b0;

        if (accept) begin
            if (i_in_item.req_type == REQ_BYTE) begin
                n_sil = '0;
                // An idle block always holds a cleared frame, so a first byte
                // is stored the same way as any other.
                unique case (r_mode)
                    MODE_IDLE: store = 1'b1;
                    MODE_RECV: begin
                        if (r_count < CW'(MAX_FRAME_BYTES)) begin
                            store = 1'b1;
                        end else begin
                            n_mode = MODE_OVER;
                        end
                    end
                    default: store = 1'b0;
                endcase

                if (store) begin
                    n_mode  = MODE_RECV;
                    n_crc   = crc_fold(r_crc, i_in_item.rx_byte);
                    n_count = r_count + CW'(1);
                    if (count_ext >= 9'd2) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_BYTE;
                        res.data_byte  = r_held0;
                        res.byte_index = 8'(count_ext - 9'd2);
                        n_held0        = r_held1;
                        n_held1        = i_in_item.rx_byte;
                    end else if (!r_count[0]) begin
                        n_held0 = i_in_item.rx_byte;
                    end else begin
                        n_held1 = i_in_item.rx_byte;
                    end
                end
            end else if (r_mode != MODE_IDLE) begin
                n_sil = sil_inc;
                if (sil_inc >= i_silence_ticks) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_VERDICT;
                    if (r_mode == MODE_OVER) begin
                        res.status = STATUS_OVERFLOW;
                        n_over     = r_over + 32'd1;
                    end else if (count_ext >= 9'(MIN_GOOD_BYTES)) begin
                        if (r_crc == 16'h0000) begin
                            res.status = STATUS_OK;
                            n_ok       = r_ok + 32'd1;
                        end else begin
                            res.status = STATUS_CRC_ERR;
                            n_crc_err  = r_crc_err + 32'd1;
                        end
                    end else begin
                        res.status = STATUS_INCOMPLETE;
                        n_short    = r_short + 32'd1;
                    end
                    res.good_frames       = n_ok;
                    res.crc_errors        = n_crc_err;
                    res.incomplete_frames = n_short;
                    res.overflows         = n_over;
                    n_mode  = MODE_IDLE;
                    n_count = '0;
                    n_crc   = CRC_INIT;
                    n_held0 = '0;
                    n_held1 = '0;
                    n_sil   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_held0     <= '0;
            r_held1     <= '0;
            r_sil       <= '0;
            r_ok        <= '0;
            r_crc_err   <= '0;
            r_short     <= '0;
            r_over      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_held0   <= n_held0;
            r_held1   <= n_held1;
            r_sil     <= n_sil;
            r_ok      <= n_ok;
            r_crc_err <= n_crc_err;
            r_short   <= n_short;
            r_over    <= n_over;
            if (accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- sv/modbus_rtu_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver: Modbus RTU receive framer with CRC-16 check
// Forwards frame bytes and gives one verdict with statistics per frame.
// ----------------------------------------------------------------------------
// Usage: the input channel carries received bytes and timer ticks. Each byte
// restarts the silence count and, unless the frame overflows, is folded into
// the CRC; each byte from the third on releases the byte received two
// positions earlier, so the two CRC bytes never leave. When silence_ticks
// ticks pass with no byte, one verdict item (ok, CRC error, incomplete or
// overflow) with the four wrapping frame counters follows; downstream keeps
// or drops the forwarded bytes by it.
// Timing: an item's result, if any, is valid in the output register in the
// cycle after the item is taken. One item per cycle is sustained while results
// are taken; the CRC byte update and the state update feed the state registers.
// Stall: while the output register holds an untaken item, a new item is
// accepted only in a cycle in which that item leaves.
// Reset: the frame state is idle, counters are zero and silence_ticks is 80.
// silence_ticks is written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mbr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mbr_pkg::t_out_item o_out_item
);
    import mbr_pkg::*;

    logic [15:0] silence_ticks;

    mbr_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_silence_ticks (silence_ticks)
    );

    mbr_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_silence_ticks (silence_ticks),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_item       (i_in_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_item      (o_out_item)
    );

endmodule
